@@ hw/rtl/cbm_pkg.sv @@
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

  // Event kinds carried with each input item
  typedef enum logic [2:0] {
    FUNC_CPU_READ  = 3'd0,
    FUNC_CPU_WRITE = 3'd1,
    FUNC_PPU_READ  = 3'd2,
    FUNC_TICK      = 3'd3,
    FUNC_IRQ_ACK   = 3'd4
  } func_e;

  // Register windows in the upper CPU half, picked by address bits 14:13
  typedef enum logic [1:0] {
    WIN_BANK   = 2'd0,
    WIN_MIRROR = 2'd1,
    WIN_IRQ_LD = 2'd2,
    WIN_IRQ_EN = 2'd3
  } win_e;

  localparam int unsigned PrgCountW = 6;
  localparam int unsigned PrgBankW  = 6;
  localparam int unsigned ChrBankW  = 8;
  localparam int unsigned MapAddrW  = 19;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;

  localparam logic [PrgCountW-1:0] PRG_COUNT_RESET = 6'd32;

  // Bits of the bank select register
  localparam int unsigned SelChrInvBit = 7;
  localparam int unsigned SelPrgSwpBit = 6;

  typedef struct packed {
    func_e              func;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   data;
  } item_t;

  typedef struct packed {
    logic                hit;
    logic [MapAddrW-1:0] rom_offset;
    logic                irq_active;
    logic                mirror_horizontal;
  } result_t;

endpackage

@@ hw/rtl/cbm_core.sv @@
// Mapper state, register writes, IRQ counter and address translation.
module cbm_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbm_pkg::PrgCountW-1:0]    cfg_wdata_i,
  input  logic                             item_valid_i,
  input  cbm_pkg::item_t                   item_i,
  output cbm_pkg::result_t                 result_o
);
  import cbm_pkg::*;

  logic [PrgCountW-1:0] prg_count_q, prg_count_d;
  logic [7:0]           bank_sel_q, bank_sel_d;
  logic [7:0]           bank_regs_q [8];
  logic [7:0]           bank_regs_d [8];
  logic [ChrBankW-1:0]  chr_tbl_q [8];
  logic [ChrBankW-1:0]  chr_tbl_d [8];
  logic [PrgBankW-1:0]  prg_tbl_q [4];
  logic [PrgBankW-1:0]  prg_tbl_d [4];
  logic [7:0]           irq_cnt_q, irq_cnt_d;
  logic [7:0]           irq_latch_q, irq_latch_d;
  logic                 irq_en_q, irq_en_d;
  logic                 irq_pend_q, irq_pend_d;
  logic                 mirror_q, mirror_d;

  logic [PrgBankW-1:0]  last_bank, second_last, last_bank_cur;
  logic                 odd, rebuild, refresh;
  logic [7:0]           r0e, r1e;
  logic [2:0]           base2k, base1k;

  // Fixed bank numbers follow the (possibly new) bank count, modulo 64
  assign last_bank     = {prg_count_d[PrgCountW-2:0], 1'b0} - PrgBankW'(1);
  assign second_last   = {prg_count_d[PrgCountW-2:0], 1'b0} - PrgBankW'(2);
  assign last_bank_cur = {prg_count_q[PrgCountW-2:0], 1'b0} - PrgBankW'(1);
  assign odd           = item_i.addr[0];

  // Apply one item or one configuration write to the state
  always_comb begin
    prg_count_d = prg_count_q;
    bank_sel_d  = bank_sel_q;
    bank_regs_d = bank_regs_q;
    chr_tbl_d   = chr_tbl_q;
    prg_tbl_d   = prg_tbl_q;
    irq_cnt_d   = irq_cnt_q;
    irq_latch_d = irq_latch_q;
    irq_en_d    = irq_en_q;
    irq_pend_d  = irq_pend_q;
    mirror_d    = mirror_q;
    rebuild     = 1'b0;
    refresh     = 1'b0;
    r0e         = '0;
    r1e         = '0;
    base2k      = '0;
    base1k      = '0;

    if (cfg_we_i) begin
      prg_count_d = cfg_wdata_i;
      refresh     = 1'b1;
    end

    if (item_valid_i) begin
      case (item_i.func)
        FUNC_CPU_WRITE: begin
          if (item_i.addr[15]) begin
            case (win_e'(item_i.addr[14:13]))
              WIN_BANK: begin
                if (!odd) begin
                  bank_sel_d = item_i.data;
                end else begin
                  bank_regs_d[bank_sel_q[2:0]] = item_i.data;
                  rebuild = 1'b1;
                end
              end
              WIN_MIRROR: begin
                if (!odd) mirror_d = item_i.data[0];
              end
              WIN_IRQ_LD: begin
                if (!odd) irq_latch_d = item_i.data;
                else      irq_cnt_d   = '0;
              end
              WIN_IRQ_EN: begin
                if (!odd) begin
                  irq_en_d   = 1'b0;
                  irq_pend_d = 1'b0;
                end else begin
                  irq_en_d = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        FUNC_TICK: begin
          irq_cnt_d = (irq_cnt_q == 8'd0) ? irq_latch_q : irq_cnt_q - 8'd1;
          if (irq_cnt_d == 8'd0 && irq_en_q) irq_pend_d = 1'b1;
        end
        FUNC_IRQ_ACK: irq_pend_d = 1'b0;
        default: ;
      endcase
    end

    // Rebuild both bank tables from the updated bank registers
    if (rebuild) begin
      r0e    = {bank_regs_d[0][7:1], 1'b0};
      r1e    = {bank_regs_d[1][7:1], 1'b0};
      base2k = bank_sel_q[SelChrInvBit] ? 3'd4 : 3'd0;
      base1k = bank_sel_q[SelChrInvBit] ? 3'd0 : 3'd4;
      chr_tbl_d[base2k]        = r0e;
      chr_tbl_d[base2k + 3'd1] = {r0e[7:1], 1'b1};
      chr_tbl_d[base2k + 3'd2] = r1e;
      chr_tbl_d[base2k + 3'd3] = {r1e[7:1], 1'b1};
      for (int i = 0; i < 4; i++) begin
        chr_tbl_d[base1k + 3'(i)] = bank_regs_d[3'(2 + i)];
      end
      if (bank_sel_q[SelPrgSwpBit]) prg_tbl_d[2] = bank_regs_d[6][PrgBankW-1:0];
      else                          prg_tbl_d[0] = bank_regs_d[6][PrgBankW-1:0];
      prg_tbl_d[1] = bank_regs_d[7][PrgBankW-1:0];
      refresh = 1'b1;
    end

    // Refresh the slots fixed to the last two banks
    if (refresh) begin
      if (bank_sel_q[SelPrgSwpBit]) prg_tbl_d[0] = second_last;
      else                          prg_tbl_d[2] = second_last;
      prg_tbl_d[3] = last_bank;
    end
  end

  // Translate reads through the tables as they stand before the item
  always_comb begin
    result_o                   = '0;
    result_o.irq_active        = irq_pend_d;
    result_o.mirror_horizontal = mirror_d;
    case (item_i.func)
      FUNC_CPU_READ: begin
        if (item_i.addr[15]) begin
          result_o.hit        = 1'b1;
          result_o.rom_offset = {prg_tbl_q[item_i.addr[14:13]], item_i.addr[12:0]};
        end
      end
      FUNC_PPU_READ: begin
        if (item_i.addr[15:13] == 3'd0) begin
          result_o.hit        = 1'b1;
          result_o.rom_offset = {1'b0, chr_tbl_q[item_i.addr[12:10]], item_i.addr[9:0]};
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PRG_COUNT_RESET;
      bank_sel_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        bank_regs_q[i] <= '0;
        chr_tbl_q[i]   <= '0;
      end
      prg_tbl_q[0] <= PrgBankW'(0);
      prg_tbl_q[1] <= PrgBankW'(1);
      prg_tbl_q[2] <= {PRG_COUNT_RESET[PrgCountW-2:0], 1'b0} - PrgBankW'(2);
      prg_tbl_q[3] <= {PRG_COUNT_RESET[PrgCountW-2:0], 1'b0} - PrgBankW'(1);
      irq_cnt_q    <= '0;
      irq_latch_q  <= '0;
      irq_en_q     <= 1'b0;
      irq_pend_q   <= 1'b0;
      mirror_q     <= 1'b1;
    end else begin
      prg_count_q <= prg_count_d;
      bank_sel_q  <= bank_sel_d;
      bank_regs_q <= bank_regs_d;
      chr_tbl_q   <= chr_tbl_d;
      prg_tbl_q   <= prg_tbl_d;
      irq_cnt_q   <= irq_cnt_d;
      irq_latch_q <= irq_latch_d;
      irq_en_q    <= irq_en_d;
      irq_pend_q  <= irq_pend_d;
      mirror_q    <= mirror_d;
    end
  end

  // The top program slot always tracks the last bank of the current count
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prg_tbl_q[3] == last_bank_cur)
    else $error("program slot 3 does not hold the last bank");

  // A pending interrupt can only exist while interrupts are enabled
  a_pend_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_pend_q |-> irq_en_q)
    else $error("interrupt pending while disabled");

  // An acknowledge always drops the interrupt line in its result
  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_i.func == FUNC_IRQ_ACK) |=> !irq_pend_q)
    else $error("acknowledge did not clear the interrupt");

endmodule

@@ hw/rtl/cartridge_bank_mapper_scanline_irq.sv @@
// Bank mapper with scanline interrupt counter: input register, core, result register.
// Accepts one event item per clock when the result side is free and returns one
// result item for each: the item is held in an input register, the mapper core
// applies it to the bank and IRQ state and translates reads in a single pass of
// logic, and the result lands in an output register. The output register lets
// a new item enter while a finished result still waits; a stall on the result
// side stops acceptance only once both registers are full. The user writes the
// bank count register through cfg_we_i while no item is in flight; the block
// itself does not enforce this.
module cartridge_bank_mapper_scanline_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // prg_bank_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] addr, [23:16] data
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [18:0] rom_offset, [19] irq_active,
                                       // [20] mirror_horizontal, [23:21] zero
  output logic        m_axis_tuser_o   // [0] hit
);
  import cbm_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q, in_item_d;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;
  result_t core_res;
  logic    advance, s_accept;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Load a new item, or drop the held one once it has moved on; move core results into the result register
  always_comb begin
    in_valid_d     = s_accept || (in_valid_q && !advance);
    in_item_d      = in_item_q;
    if (s_accept) begin
      in_item_d.func = func_e'(s_axis_tuser_i);
      in_item_d.addr = s_axis_tdata_i[15:0];
      in_item_d.data = s_axis_tdata_i[23:16];
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
    out_res_d   = (advance && in_valid_q) ? core_res : out_res_q;
  end

  cbm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (in_valid_q && advance),
    .item_i       (in_item_q),
    .result_o     (core_res)
  );

  // Handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.hit;
  assign m_axis_tdata_o  = {3'b000, out_res_q.mirror_horizontal, out_res_q.irq_active,
                            out_res_q.rom_offset};

  // An item handed to the core shows up as a result in the next cycle
  a_core_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // With the result register free, the block always takes an item
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // A non-read result never carries a hit
  a_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance && in_item_q.func != FUNC_CPU_READ
     && in_item_q.func != FUNC_PPU_READ) |=> !out_res_q.hit)
    else $error("hit flagged for a non-read item");

endmodule
